// ===== rtl/assert_macros.svh =====
// Assertion helpers, sampled on aclk and held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SHFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/shfr_pkg.sv =====
package shfr_pkg;

    localparam int PAGE_BYTES   = 512;
    localparam int SHORT_BODY   = 8;
    localparam int LONG_BODY    = SHORT_BODY + PAGE_BYTES;
    localparam int CNT_W        = $clog2(LONG_BODY + 1);
    localparam int IDX_W        = 10;
    localparam int TICK_W       = 20;
    localparam int SUM_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int OUT_DATA_W   = 32;

    localparam logic [7:0] HDR_BYTE0 = 8'd1;
    localparam logic [7:0] HDR_BYTE1 = 8'd2;
    localparam logic [7:0] HDR_BYTE2 = 8'd3;
    // sum of the three header bytes, seeded on the opcode
    localparam logic [SUM_W-1:0] HDR_SUM = SUM_W'(6);

    localparam logic [TICK_W-1:0] BOOT_TIMEOUT_RST = TICK_W'(880000);
    localparam logic [TICK_W-1:0] RX_TIMEOUT_RST   = TICK_W'(293330);

    // input kinds (tuser)
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE_OPCODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NO_ERROR_CODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAY_IN_BOOT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_TIMEOUT_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RX_TIMEOUT_TICKS   = 3'd4;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_OPCODE,
        PH_ERROR,
        PH_BODY,
        PH_CK_LO,
        PH_CK_HI
    } phase_t;

    typedef struct packed {
        logic [7:0]        page_size_opcode;
        logic [7:0]        no_error_code;
        logic              stay_in_boot;
        logic [TICK_W-1:0] boot_timeout_ticks;
        logic [TICK_W-1:0] rx_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic             exit_boot;
        logic             short_frame;
        logic [7:0]       frame_opcode;
        logic             frame_ok;
        logic             frame_done;
        logic [IDX_W-1:0] body_index;
        logic [7:0]       body_byte;
        logic             body_valid;
    } result_t;

endpackage

// ===== rtl/shfr_parse.sv =====
module shfr_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic              kind,
    input  logic [7:0]        rx_byte,
    input  shfr_pkg::cfg_t    cfg,
    output shfr_pkg::result_t res
);
    import shfr_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [7:0]         opcode_reg, opcode_next;
    logic [7:0]         error_reg, error_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [7:0]         ck_lo_reg, ck_lo_next;
    logic [TICK_W-1:0]  idle_reg, idle_next;

    logic               is_short;
    logic [CNT_W-1:0]   body_len;
    logic [CNT_W-1:0]   count_inc;
    logic [TICK_W-1:0]  idle_inc;
    logic [31:0]        count_wide;
    logic [SUM_W-1:0]   rx_sum;

    assign is_short   = (opcode_reg == cfg.page_size_opcode);
    assign body_len   = is_short ? CNT_W'(SHORT_BODY) : CNT_W'(LONG_BODY);
    assign count_inc  = count_reg + CNT_W'(1);
    assign idle_inc   = idle_reg + TICK_W'(1);
    assign count_wide = 32'(count_reg);
    assign rx_sum     = {rx_byte, ck_lo_reg};

    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        error_next  = error_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        ck_lo_next  = ck_lo_reg;
        idle_next   = idle_reg;
        res         = '0;

        if (kind == KIND_TICK) begin
            // ticks are dropped while a body or checksum is in flight
            if (!(phase_reg inside {PH_BODY, PH_CK_LO, PH_CK_HI})) begin
                idle_next = idle_inc;
                if (idle_inc == cfg.rx_timeout_ticks) begin
                    phase_next = PH_HDR0;
                end
                if (idle_inc == cfg.boot_timeout_ticks) begin
                    idle_next     = '0;
                    res.exit_boot = !cfg.stay_in_boot;
                end
            end
        end else begin
            idle_next = '0;
            case (phase_reg)
                PH_HDR0: begin
                    phase_next = (rx_byte == HDR_BYTE0) ? PH_HDR1 : PH_HDR0;
                end
                PH_HDR1: begin
                    phase_next = (rx_byte == HDR_BYTE1) ? PH_HDR2 : PH_HDR0;
                end
                PH_HDR2: begin
                    phase_next = (rx_byte == HDR_BYTE2) ? PH_OPCODE : PH_HDR0;
                end
                PH_OPCODE: begin
                    opcode_next = rx_byte;
                    sum_next    = HDR_SUM + SUM_W'(rx_byte);
                    phase_next  = PH_ERROR;
                end
                PH_ERROR: begin
                    error_next = rx_byte;
                    sum_next   = sum_reg + SUM_W'(rx_byte);
                    count_next = '0;
                    phase_next = PH_BODY;
                end
                PH_BODY: begin
                    res.body_valid = 1'b1;
                    res.body_byte  = rx_byte;
                    res.body_index = count_wide[IDX_W-1:0];
                    sum_next       = sum_reg + SUM_W'(rx_byte);
                    count_next     = count_inc;
                    // a shortened length mid-frame ends the body at once
                    if (count_inc >= body_len) begin
                        phase_next = PH_CK_LO;
                    end
                end
                PH_CK_LO: begin
                    ck_lo_next = rx_byte;
                    phase_next = PH_CK_HI;
                end
                PH_CK_HI: begin
                    res.frame_done   = 1'b1;
                    res.frame_ok     = (rx_sum == sum_reg) &&
                                       (error_reg == cfg.no_error_code);
                    res.frame_opcode = opcode_reg;
                    res.short_frame  = is_short;
                    phase_next       = PH_HDR0;
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            error_reg  <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            ck_lo_reg  <= '0;
            idle_reg   <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            error_reg  <= error_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            ck_lo_reg  <= ck_lo_next;
            idle_reg   <= idle_next;
        end
    end

endmodule

// ===== rtl/sync_header_frame_receiver.sv =====
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tdata: rx_byte; s_tuser: kind
// m_        out        m_tvalid / m_tready    m_tdata: result fields; m_tlast: frame_done
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat per clock while s_tready is high; each result is registered in the output
// register, via skid_reg if stalled. Sum and phase update by one 16-bit add and compare.
// Output register plus skid stage: s_tready falls only when both hold a waiting result.
// aresetn is synchronous; it clears the parser and both valid flags, restores config regs.
// cfg_ready is always high.
module sync_header_frame_receiver (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    input  logic                                s_tuser,   // [0] kind

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] body_valid, [8:1] body_byte, [18:9] body_index, [19] frame_ok,
    // [27:20] frame_opcode, [28] short_frame, [29] exit_boot, [31:30] zero
    output logic [shfr_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast,   // frame_done

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [shfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [shfr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import shfr_pkg::*;
    `include "assert_macros.svh"

    cfg_t    cfg_reg;
    result_t new_res;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    in_beat;

    assign s_tready  = !skid_valid_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.page_size_opcode   <= '0;
            cfg_reg.no_error_code      <= '0;
            cfg_reg.stay_in_boot       <= 1'b0;
            cfg_reg.boot_timeout_ticks <= BOOT_TIMEOUT_RST;
            cfg_reg.rx_timeout_ticks   <= RX_TIMEOUT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PAGE_SIZE_OPCODE:   cfg_reg.page_size_opcode   <= cfg_data[7:0];
                REG_NO_ERROR_CODE:      cfg_reg.no_error_code      <= cfg_data[7:0];
                REG_STAY_IN_BOOT:       cfg_reg.stay_in_boot       <= cfg_data[0];
                REG_BOOT_TIMEOUT_TICKS: cfg_reg.boot_timeout_ticks <= cfg_data[TICK_W-1:0];
                REG_RX_TIMEOUT_TICKS:   cfg_reg.rx_timeout_ticks   <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    shfr_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (in_beat),
        .kind    (s_tuser),
        .rx_byte (s_tdata),
        .cfg     (cfg_reg),
        .res     (new_res)
    );

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || in_beat;
            skid_valid_reg <= 1'b0;
        end else if (in_beat) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : new_res;
        end else if (in_beat) begin
            skid_reg <= new_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.frame_done;
    assign m_tdata  = {2'b00,
                       out_reg.exit_boot,
                       out_reg.short_frame,
                       out_reg.frame_opcode,
                       out_reg.frame_ok,
                       out_reg.body_index,
                       out_reg.body_byte,
                       out_reg.body_valid};

    `SHFR_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `SHFR_ASSERT_NOW(a_done_not_body, m_tvalid && m_tlast, !m_tdata[0] && !m_tdata[29], "frame end beat also marked body or exit")
    `SHFR_ASSERT_NEXT(a_beat_lands, in_beat, m_tvalid, "accepted beat produced no result")

endmodule
